@@ design/tsc_pkg.sv @@
// Package for the temperature scratchpad checker: constants, types and CRC and mask functions.
package tsc_pkg;

	localparam int unsigned ScratchLen = 9;
	localparam int unsigned CrcLen     = 8;
	localparam int unsigned PosW       = 4;

	localparam logic [7:0]  CrcPoly    = 8'h8C;
	localparam logic [15:0] Mask9Bit   = 16'hFFF8;
	localparam logic [15:0] Mask10Bit  = 16'hFFFC;
	localparam logic [15:0] Mask11Bit  = 16'hFFFE;

	localparam logic [1:0] Res9Bit  = 2'd0;
	localparam logic [1:0] Res10Bit = 2'd1;
	localparam logic [1:0] Res11Bit = 2'd2;

	localparam logic [PosW-1:0] PosCrcByte = PosW'(CrcLen);
	localparam logic [PosW-1:0] PosDone    = PosW'(ScratchLen);
	localparam logic [PosW-1:0] PosTempLo  = PosW'(0);
	localparam logic [PosW-1:0] PosTempHi  = PosW'(1);
	localparam logic [PosW-1:0] PosConfig  = PosW'(4);

	typedef struct packed {
		logic               emit;
		logic signed [15:0] temperature_sixteenths;
		logic               crc_ok;
		logic [1:0]         resolution_code;
		logic [7:0]         computed_crc;
	} tsc_result_t;

	// reflected CRC-8, one byte
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic [15:0] mask_temp(input logic [15:0] raw, input logic [1:0] res);
		logic [15:0] m;
		case (res)
			Res9Bit:  m = raw & Mask9Bit;
			Res10Bit: m = raw & Mask10Bit;
			Res11Bit: m = raw & Mask11Bit;
			default:  m = raw;
		endcase
		return m;
	endfunction

endpackage

@@ design/tsc_frame.sv @@
// Frame tracker: byte count, running CRC, temperature and resolution capture, result build.
module tsc_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           scratch_byte,
	input  logic                 frame_start,
	output tsc_pkg::tsc_result_t result
);
	import tsc_pkg::*;

	logic [PosW-1:0] pos_q;
	logic [7:0]      crc_q;
	logic [7:0]      temp_lo_q;
	logic [7:0]      temp_hi_q;
	logic [1:0]      res_q;

	logic [PosW-1:0] pos_eff;
	logic [7:0]      crc_eff;
	logic [7:0]      crc_next;

	always_comb begin
		pos_eff  = frame_start ? '0 : pos_q;
		crc_eff  = frame_start ? '0 : crc_q;
		crc_next = crc8_step(crc_eff, scratch_byte);

		result.emit                   = (pos_eff == PosCrcByte);
		result.temperature_sixteenths = mask_temp({temp_hi_q, temp_lo_q}, res_q);
		result.crc_ok                 = (crc_eff == scratch_byte);
		result.resolution_code        = res_q;
		result.computed_crc           = crc_eff;
	end

	// past the ninth byte without a flag nothing changes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= '0;
			temp_lo_q <= '0;
			temp_hi_q <= '0;
			res_q     <= '0;
		end else if (step) begin
			if (pos_eff < PosCrcByte) begin
				crc_q <= crc_next;
				pos_q <= PosW'(pos_eff + 1'b1);
				if (pos_eff == PosTempLo) begin
					temp_lo_q <= scratch_byte;
				end
				if (pos_eff == PosTempHi) begin
					temp_hi_q <= scratch_byte;
				end
				if (pos_eff == PosConfig) begin
					res_q <= scratch_byte[6:5];
				end
			end else if (pos_eff == PosCrcByte) begin
				pos_q <= PosDone;
			end
		end
	end

endmodule

@@ design/temp_scratchpad_checker.sv @@
// Top level of the temperature scratchpad checker: input register, frame tracker, result register.
//
// Accepts one scratchpad byte per cycle on the byte channel and emits one result on the
// result channel for the ninth byte of each frame (frame_start marks byte 0). A byte is
// captured in an input register, processed against the frame state when it leaves that register
// (one CRC byte step), and the result lands in an output register at that same edge, so result_valid
// rises at the edge that processes its ninth byte. Sustained rate is one byte per cycle;
// the byte channel stalls only when a finished result is held waiting for result_ready and
// another ninth byte needs the output register.
module temp_scratchpad_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  logic [7:0]         scratch_byte,
	input  logic               frame_start,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [15:0] temperature_sixteenths,
	output logic               crc_ok,
	output logic [1:0]         resolution_code,
	output logic [7:0]         computed_crc
);
	import tsc_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        advance;
	tsc_result_t res;

	tsc_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.scratch_byte (byte_s1),
		.frame_start  (start_s1),
		.result       (res)
	);

	assign advance    = valid_s1 && (!res.emit || !result_valid || result_ready);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			byte_s1  <= scratch_byte;
			start_s1 <= frame_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && res.emit) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			temperature_sixteenths <= res.temperature_sixteenths;
			crc_ok                 <= res.crc_ok;
			resolution_code        <= res.resolution_code;
			computed_crc           <= res.computed_crc;
		end
	end

endmodule
